FILE: hw/rtl/pipu_pkg.sv
// shared types, constants and helpers for the point-in-polygon test unit
// no dependencies; imported by the interface, vertex store, edge pipe and top-level files
`default_nettype none

package pipu_pkg;

   localparam int MAX_VERTICES = 64;
   localparam int VIDX_W       = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
   localparam int CNT_W        = $clog2(MAX_VERTICES + 1);

   localparam int COORD_W  = 16;
   localparam int DIFF_W   = COORD_W + 1;
   localparam int PROD_W   = 2 * DIFF_W;
   localparam int CSR_W    = 7;
   localparam int INIDX_W  = 6;

   localparam logic ACT_LOAD  = 1'b0;
   localparam logic ACT_QUERY = 1'b1;

   typedef logic signed [COORD_W-1:0] coord_type;
   typedef logic signed [DIFF_W-1:0]  diff_type;
   typedef logic signed [PROD_W-1:0]  prod_type;

   typedef struct packed {
      logic [COORD_W-1:0] x;
      logic [COORD_W-1:0] y;
   } vertex_type;

   // one closed edge handed from the sequencer to the arithmetic pipe
   typedef struct packed {
      logic       valid;
      logic       last;
      vertex_type a;
      vertex_type b;
   } edge_type;

   // tag that travels beside a store read
   typedef struct packed {
      logic valid;
      logic first;
      logic last;
   } rd_tag_type;

   typedef struct packed {
      logic done;
      logic odd;
   } pipe_status_type;

   function automatic logic [CNT_W-1:0] clamp_count(input logic [CSR_W-1:0] c);
      if (32'(c) > MAX_VERTICES) begin
         return CNT_W'(MAX_VERTICES);
      end
      return CNT_W'(c);
   endfunction

   function automatic logic index_in_range(input logic [INIDX_W-1:0] idx);
      return (32'(idx) < MAX_VERTICES);
   endfunction

   function automatic diff_type sub17(input logic [COORD_W-1:0] a,
                                      input logic [COORD_W-1:0] b);
      return $signed({a[COORD_W-1], a}) - $signed({b[COORD_W-1], b});
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/pipu_if.sv
// request and response channel interfaces of the point-in-polygon test unit
// depends on pipu_pkg
`default_nettype none

interface pipu_req_if import pipu_pkg::*;;
   logic                 valid;
   logic                 ready;
   logic                 action;
   logic [INIDX_W-1:0]   vertex_index;
   coord_type            coord_x;
   coord_type            coord_y;

   modport source (output valid, action, vertex_index, coord_x, coord_y, input ready);
   modport sink   (input valid, action, vertex_index, coord_x, coord_y, output ready);
endinterface

interface pipu_rsp_if;
   logic valid;
   logic ready;
   logic inside_res;

   modport source (output valid, inside_res, input ready);
   modport sink   (input valid, inside_res, output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/pipu_vertex_store.sv
// vertex memory: one write port, one read port with registered read data
// depends on pipu_pkg
`default_nettype none

module pipu_vertex_store import pipu_pkg::*; (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [VIDX_W-1:0] wr_addr,
   input  vertex_type        wr_data,
   input  logic              rd_en,
   input  logic [VIDX_W-1:0] rd_addr,
   output vertex_type        rd_data
);

   vertex_type mem [MAX_VERTICES];
   vertex_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/pipu_edge_pipe.sv
// three-stage crossing test of one edge per cycle and the parity accumulator
// stage 1 classifies and takes differences, stage 2 multiplies, stage 3 compares
// depends on pipu_pkg
`default_nettype none

module pipu_edge_pipe import pipu_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            clear,
   input  vertex_type      point,
   input  edge_type        edge_in,
   output pipe_status_type status
);

   // stage 1
   logic     s1_valid_ff, s1_valid_in;
   logic     s1_last_ff, s1_last_in;
   logic     s1_fixed_ff, s1_fixed_in;
   logic     s1_fixval_ff, s1_fixval_in;
   logic     s1_bup_ff, s1_bup_in;
   diff_type s1_d1_ff, s1_d1_in;
   diff_type s1_d2_ff, s1_d2_in;
   diff_type s1_d3_ff, s1_d3_in;
   diff_type s1_d4_ff, s1_d4_in;
   // stage 2
   logic     s2_valid_ff, s2_valid_in;
   logic     s2_last_ff, s2_last_in;
   logic     s2_fixed_ff, s2_fixed_in;
   logic     s2_fixval_ff, s2_fixval_in;
   logic     s2_bup_ff, s2_bup_in;
   prod_type s2_lhs_ff, s2_lhs_in;
   prod_type s2_rhs_ff, s2_rhs_in;
   // stage 3
   logic     parity_ff, parity_in;
   logic     done_ff, done_in;

   coord_type ax, ay, bx, by, px, py;
   coord_type up_x, up_y, lo_y;
   logic      horiz, skip, up_at, lo_at, hit;

   assign ax = $signed(edge_in.a.x);
   assign ay = $signed(edge_in.a.y);
   assign bx = $signed(edge_in.b.x);
   assign by = $signed(edge_in.b.y);
   assign px = $signed(point.x);
   assign py = $signed(point.y);

   always_comb begin
      horiz = (ay == by);
      skip  = horiz || ((ay > py) && (by > py)) || ((ay < py) && (by < py));
      if (by > ay) begin
         up_y = by;
         up_x = bx;
         lo_y = ay;
      end else begin
         up_y = ay;
         up_x = ax;
         lo_y = by;
      end
      up_at = (up_y == py);
      lo_at = (lo_y == py);

      s1_valid_in  = edge_in.valid;
      s1_last_in   = edge_in.last;
      s1_fixed_in  = skip || up_at || lo_at;
      s1_fixval_in = !skip && up_at && (up_x >= px);
      s1_bup_in    = (by > ay);
      s1_d1_in     = sub17(point.y, edge_in.a.y);
      s1_d2_in     = sub17(edge_in.b.x, edge_in.a.x);
      s1_d3_in     = sub17(point.x, edge_in.a.x);
      s1_d4_in     = sub17(edge_in.b.y, edge_in.a.y);
   end

   always_comb begin
      s2_valid_in  = s1_valid_ff;
      s2_last_in   = s1_last_ff;
      s2_fixed_in  = s1_fixed_ff;
      s2_fixval_in = s1_fixval_ff;
      s2_bup_in    = s1_bup_ff;
      s2_lhs_in    = s1_d1_ff * s1_d2_ff;
      s2_rhs_in    = s1_d3_ff * s1_d4_ff;
   end

   always_comb begin
      if (s2_fixed_ff) begin
         hit = s2_fixval_ff;
      end else if (s2_bup_ff) begin
         hit = (s2_lhs_ff >= s2_rhs_ff);
      end else begin
         hit = (s2_lhs_ff <= s2_rhs_ff);
      end
      parity_in = parity_ff;
      if (clear) begin
         parity_in = 1'b0;
      end else if (s2_valid_ff) begin
         parity_in = parity_ff ^ hit;
      end
      done_in = s2_valid_ff && s2_last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         done_ff     <= 1'b0;
         parity_ff   <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s2_valid_in;
         done_ff     <= done_in;
         parity_ff   <= parity_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_last_ff   <= s1_last_in;
      s1_fixed_ff  <= s1_fixed_in;
      s1_fixval_ff <= s1_fixval_in;
      s1_bup_ff    <= s1_bup_in;
      s1_d1_ff     <= s1_d1_in;
      s1_d2_ff     <= s1_d2_in;
      s1_d3_ff     <= s1_d3_in;
      s1_d4_ff     <= s1_d4_in;
      s2_last_ff   <= s2_last_in;
      s2_fixed_ff  <= s2_fixed_in;
      s2_fixval_ff <= s2_fixval_in;
      s2_bup_ff    <= s2_bup_in;
      s2_lhs_ff    <= s2_lhs_in;
      s2_rhs_ff    <= s2_rhs_in;
   end

   assign status.done = done_ff;
   assign status.odd  = parity_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/point_in_polygon_test_unit.sv
// point-in-polygon test unit: a load writes one store entry; a query with n vertices in use
// reads n+1 store entries, one per cycle, through a read stage and a three-stage edge pipe,
// and shows its result once the last edge has left the pipe (no entries are read when n is zero)
// requests are taken only while idle, so the next item waits until the result is registered
// synchronous active-high reset clears the count register, sequencer and valid bits;
// the vertex store is not cleared and must be loaded before it is queried
`default_nettype none

module point_in_polygon_test_unit import pipu_pkg::*; (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CSR_W-1:0] csr_wdata,
   pipu_req_if.sink         req,
   pipu_rsp_if.source       rsp
);

   localparam logic [1:0] S_IDLE  = 2'd0;
   localparam logic [1:0] S_RUN   = 2'd1;
   localparam logic [1:0] S_DRAIN = 2'd2;
   localparam logic [1:0] S_OUT   = 2'd3;

   logic [1:0]       state_ff, state_in;
   logic [CSR_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] n_ff, n_in;
   vertex_type       point_ff, point_in;
   vertex_type       prev_ff, prev_in;
   rd_tag_type       rd_tag_ff, rd_tag_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_res_ff, rsp_res_in;

   logic              req_xfer, query_xfer, load_xfer, issue;
   logic [CNT_W-1:0]  n_req;
   logic [VIDX_W-1:0] rd_addr, wr_addr;
   vertex_type        wr_data, rd_data;
   edge_type          edge_bus;
   pipe_status_type   status;

   assign req.ready  = (state_ff == S_IDLE);
   assign req_xfer   = req.valid && req.ready;
   assign query_xfer = req_xfer && (req.action == ACT_QUERY);
   assign load_xfer  = req_xfer && (req.action == ACT_LOAD) && index_in_range(req.vertex_index);
   assign n_req      = clamp_count(count_ff);

   assign wr_addr   = VIDX_W'(req.vertex_index);
   assign wr_data.x = req.coord_x;
   assign wr_data.y = req.coord_y;

   // the closing edge comes from reading entry zero once more after the last vertex
   assign rd_addr = (cnt_ff == n_ff) ? '0 : cnt_ff[VIDX_W-1:0];

   always_comb begin
      count_in     = csr_we ? csr_wdata : count_ff;
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      n_in         = n_ff;
      point_in     = point_ff;
      rsp_valid_in = rsp_valid_ff && !rsp.ready;
      rsp_res_in   = rsp_res_ff;
      issue        = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (query_xfer) begin
               point_in.x = req.coord_x;
               point_in.y = req.coord_y;
               n_in       = n_req;
               cnt_in     = '0;
               state_in   = (n_req == '0) ? S_OUT : S_RUN;
            end
         end
         S_RUN: begin
            issue  = 1'b1;
            cnt_in = cnt_ff + CNT_W'(1);
            if (cnt_ff == n_ff) begin
               state_in = S_DRAIN;
            end
         end
         S_DRAIN: begin
            if (status.done) begin
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!rsp_valid_ff || rsp.ready) begin
               rsp_valid_in = 1'b1;
               rsp_res_in   = status.odd;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      rd_tag_in.valid = issue;
      rd_tag_in.first = (cnt_ff == '0);
      rd_tag_in.last  = (cnt_ff == n_ff);
      prev_in         = rd_tag_ff.valid ? rd_data : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_tag_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_tag_ff    <= rd_tag_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cnt_ff     <= cnt_in;
      n_ff       <= n_in;
      point_ff   <= point_in;
      prev_ff    <= prev_in;
      rsp_res_ff <= rsp_res_in;
   end

   assign edge_bus.valid = rd_tag_ff.valid && !rd_tag_ff.first;
   assign edge_bus.last  = rd_tag_ff.last;
   assign edge_bus.a     = prev_ff;
   assign edge_bus.b     = rd_data;

   pipu_vertex_store u_store (
      .clock   (clock),
      .wr_en   (load_xfer),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (issue),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   pipu_edge_pipe u_edge_pipe (
      .clock   (clock),
      .reset   (reset),
      .clear   (query_xfer),
      .point   (point_ff),
      .edge_in (edge_bus),
      .status  (status)
   );

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.inside_res = rsp_res_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/pipu_checker.sv
// port-level checks of the point-in-polygon test unit and the bind that attaches them
// depends on point_in_polygon_test_unit and its channel interfaces
`default_nettype none

module pipu_checker (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   input wire logic req_ready,
   input wire logic req_action,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire logic rsp_inside_res
);

   // a stalled result transfer keeps its value
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_inside_res))
      else $error("result dropped or changed while stalled");

   // reset leaves no result pending
   assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result pending after reset");

   // a load never produces a result
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_action && !rsp_valid |=> !rsp_valid)
      else $error("result after a load transfer");

   // a query leaves the unit busy, so ready drops after its transfer
   assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && req_action |=> !req_ready)
      else $error("request taken right after a query");

endmodule

bind point_in_polygon_test_unit pipu_checker u_pipu_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req.valid),
   .req_ready      (req.ready),
   .req_action     (req.action),
   .rsp_valid      (rsp.valid),
   .rsp_ready      (rsp.ready),
   .rsp_inside_res (rsp.inside_res)
);

`default_nettype wire
